[rtl/fpr_pkg.sv]
// ----------------------------------------------------------------------------
// Frame pacing rate meter package
// Shared widths, defaults and request codes of the frame pacing rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

    localparam int WINDOW_DEF          = 120;
    localparam int UPDATE_INTERVAL_DEF = 60;

    localparam int STAMP_W    = 32;
    localparam int WAIT_W     = 11;
    localparam int RATE_W     = 21;
    localparam int OUT_DATA_W = WAIT_W + RATE_W;

    // Rate division: numerator 20000*(len-1) + span, denominator 2*span.
    localparam int DIV_W       = 33;
    localparam int RATE_NUM_MS = 20000;

    // Expected window time is len*50/3 ms; division by 3 uses a reciprocal.
    localparam int FRAME_MS_X3 = 50;
    localparam int RECIP3      = 21846;
    localparam int RECIP3_SH   = 16;

    localparam logic FUNC_QUERY    = 1'b0;
    localparam logic FUNC_REGISTER = 1'b1;

endpackage

`default_nettype wire

[rtl/frame_pacing_rate_meter.sv]
// ----------------------------------------------------------------------------
// Frame pacing rate meter
// A query gives its result after the issue, read and done states; so does a
// frame registration, except one that measures the rate, where the 33-step
// serial divider sets the pace. One request is handled at a time and another
// is accepted once the meter has returned to idle after the result is issued;
// a stalled result holds the meter in its done state.
// Reset empties the window and clears the counters and the measured rate at
// once; the timestamp RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pacing_rate_meter #(
    parameter int WINDOW          = fpr_pkg::WINDOW_DEF,
    parameter int UPDATE_INTERVAL = fpr_pkg::UPDATE_INTERVAL_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [fpr_pkg::STAMP_W-1:0]     s_axis_tdata,  // now_ms
    input  wire logic                            s_axis_tuser,  // func
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [fpr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // wait_ms, rate_tenths
    output logic                                 m_axis_tuser   // rate_valid
);

    import fpr_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int SUM_W   = FILL_W + 1;
    localparam int TALLY_W = $clog2(UPDATE_INTERVAL + 1);
    localparam int PROD_W  = $clog2(WINDOW * FRAME_MS_X3 + 1);
    localparam int EXP_W   = $clog2(WINDOW * FRAME_MS_X3 / 3 + 1);
    localparam int SCL_W   = PROD_W + RECIP3_SH;

    localparam logic [DIV_W-1:0]  NUM_BASE = DIV_W'(RATE_NUM_MS * (WINDOW - 1));
    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISSUE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic               func_reg, func_next;
    logic [STAMP_W-1:0] now_reg, now_next;
    logic [SLOT_W-1:0]  ws_reg, ws_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic               meas_reg, meas_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic               seen_reg, seen_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;
    logic [EXP_W-1:0]   expected_reg, expected_next;
    logic               out_valid_reg, out_valid_next;
    logic [WAIT_W-1:0]  out_wait_reg, out_wait_next;
    logic [RATE_W-1:0]  out_rate_reg, out_rate_next;
    logic               out_seen_reg, out_seen_next;

    logic               in_acc;
    logic               out_free;
    logic [SLOT_W-1:0]  ws_inc;
    logic [SUM_W-1:0]   oldest_wide;
    logic [SLOT_W-1:0]  oldest;
    logic [FILL_W-1:0]  fill_after;
    logic [TALLY_W:0]   tally_inc;
    logic               hit;
    logic [PROD_W-1:0]  prod;
    logic [SCL_W-1:0]   scaled;
    logic [STAMP_W-1:0] elapsed;
    logic [STAMP_W-1:0] exp_ext;
    logic [STAMP_W-1:0] wait_diff;
    logic [WAIT_W-1:0]  wait_calc;
    logic [STAMP_W-1:0] span;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [STAMP_W-1:0] ram_rdata;

    logic               div_start;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;

    fpr_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (WINDOW)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ws_reg),
        .wdata (now_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fpr_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (NUM_BASE + {1'b0, span}),
        .den      ({span, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign ws_inc = (ws_reg == SLOT_W'(WINDOW - 1)) ? '0 : ws_reg + SLOT_W'(1);

    always_comb
    begin
        if (SUM_W'(ws_reg) >= SUM_W'(fill_reg))
        begin
            oldest_wide = SUM_W'(ws_reg) - SUM_W'(fill_reg);
        end
        else
        begin
            oldest_wide = SUM_W'(ws_reg) + SUM_W'(WINDOW) - SUM_W'(fill_reg);
        end
    end
    assign oldest = oldest_wide[SLOT_W-1:0];

    assign fill_after = (fill_reg == FILL_W'(WINDOW)) ? fill_reg : fill_reg + FILL_W'(1);
    assign tally_inc  = (TALLY_W + 1)'(tally_reg) + (TALLY_W + 1)'(1);
    assign hit        = (tally_inc >= (TALLY_W + 1)'(UPDATE_INTERVAL));

    assign prod   = PROD_W'(fill_reg) * PROD_W'(FRAME_MS_X3);
    assign scaled = SCL_W'(prod) * SCL_W'(RECIP3);

    assign elapsed   = now_reg - ram_rdata;
    assign exp_ext   = STAMP_W'(expected_reg);
    assign wait_diff = (exp_ext > elapsed) ? exp_ext - elapsed : '0;
    assign wait_calc = (wait_diff > STAMP_W'(WAIT_MAX)) ? WAIT_MAX : wait_diff[WAIT_W-1:0];
    assign span      = now_reg - ram_rdata;

    assign ram_we    = (state_reg == S_ISSUE) && (func_reg == FUNC_REGISTER);
    assign ram_raddr = (func_reg == FUNC_REGISTER) ? ws_inc : oldest;

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        now_next      = now_reg;
        ws_next       = ws_reg;
        fill_next     = fill_reg;
        tally_next    = tally_reg;
        meas_next     = meas_reg;
        rate_next     = rate_reg;
        seen_next     = seen_reg;
        wait_next     = wait_reg;
        expected_next = expected_reg;
        out_wait_next = out_wait_reg;
        out_rate_next = out_rate_reg;
        out_seen_next = out_seen_reg;
        div_start     = 1'b0;
        out_valid_next = m_axis_tready ? 1'b0 : out_valid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    func_next  = s_axis_tuser;
                    now_next   = s_axis_tdata;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                expected_next = scaled[RECIP3_SH +: EXP_W];
                meas_next     = 1'b0;
                if (func_reg == FUNC_REGISTER)
                begin
                    ws_next    = ws_inc;
                    fill_next  = fill_after;
                    tally_next = hit ? '0 : tally_inc[TALLY_W-1:0];
                    meas_next  = hit && (fill_after == FILL_W'(WINDOW));
                end
                state_next = S_READ;
            end
            S_READ:
            begin
                if (func_reg == FUNC_QUERY)
                begin
                    wait_next  = (fill_reg == '0) ? '0 : wait_calc;
                    state_next = S_DONE;
                end
                else
                begin
                    wait_next = '0;
                    if (meas_reg && (span != '0))
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rate_next  = (div_q > DIV_W'(RATE_MAX)) ? RATE_MAX : div_q[RATE_W-1:0];
                    seen_next  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_wait_next  = wait_reg;
                    out_rate_next  = rate_reg;
                    out_seen_next  = seen_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= '0;
            fill_reg      <= '0;
            tally_reg     <= '0;
            meas_reg      <= 1'b0;
            rate_reg      <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            fill_reg      <= fill_next;
            tally_reg     <= tally_next;
            meas_reg      <= meas_next;
            rate_reg      <= rate_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        now_reg      <= now_next;
        wait_reg     <= wait_next;
        expected_reg <= expected_next;
        out_wait_reg <= out_wait_next;
        out_rate_reg <= out_rate_next;
        out_seen_reg <= out_seen_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_rate_reg, out_wait_reg};
    assign m_axis_tuser  = out_seen_reg;

endmodule

`default_nettype wire

[rtl/fpr_ram.sv]
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 120,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/fpr_div.sv]
// ----------------------------------------------------------------------------
// Frame pacing rate meter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_div #(
    parameter int W = fpr_pkg::DIV_W
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic              done,
    output logic      [W-1:0] quotient
);

    import fpr_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W:0]       rem_shift;
    logic [W+1:0]     diff;

    assign rem_shift = {rem_reg, quo_reg[W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (diff[W+1])
            begin
                rem_next = rem_shift[W-1:0];
            end
            else
            begin
                rem_next = diff[W-1:0];
            end
            quo_next = {quo_reg[W-2:0], ~diff[W+1]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[verif/frame_pacing_rate_meter_tb.sv]
// ----------------------------------------------------------------------------
// Frame pacing rate meter testbench
// Sends query and frame registration requests to the meter. It predicts
// each result from its own model of the timestamp window, the frame tally
// and the measured rate, and compares every returned result field by field.
// Both stream sides idle at random, and the result side holds off for long
// stretches so that the meter stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pacing_rate_meter_tb;

    import fpr_pkg::*;

    localparam int WINDOW          = WINDOW_DEF;
    localparam int UPDATE_INTERVAL = UPDATE_INTERVAL_DEF;
    localparam int SLOT_W          = $clog2(WINDOW);
    localparam int FILL_W          = $clog2(WINDOW + 1);
    localparam int TALLY_W         = $clog2(UPDATE_INTERVAL + 1);
    localparam int WAIT_MAX        = 2047;
    localparam int RATE_MAX        = 2097151;
    localparam int REQUEST_TOTAL   = 1350;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic               func;
        logic [STAMP_W-1:0] now_ms;
    } frame_request_t;

    typedef struct packed {
        logic [WAIT_W-1:0] wait_ms;
        logic [RATE_W-1:0] rate_tenths;
        logic              rate_valid;
    } pacing_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [STAMP_W-1:0]    s_axis_tdata  = '0;
    logic                  s_axis_tuser  = FUNC_QUERY;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    frame_request_t frame_requests[$];
    pacing_result_t awaited_results[$];
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count    = 0;
    int unsigned    hold_left      = 0;

    logic [STAMP_W-1:0] stamps [WINDOW];
    logic [SLOT_W-1:0]  write_slot  = '0;
    logic [FILL_W-1:0]  fill_count  = '0;
    logic [TALLY_W-1:0] frame_tally = '0;
    logic [RATE_W-1:0]  rate_value  = '0;
    logic               rate_seen   = 1'b0;

    frame_pacing_rate_meter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [SLOT_W-1:0] oldest_index();
        return SLOT_W'((int'(write_slot) + WINDOW - int'(fill_count)) % WINDOW);
    endfunction

    function automatic pacing_result_t pacing_outcome(logic func, logic [STAMP_W-1:0] now_ms);
        pacing_result_t     res;
        int unsigned        budget;
        logic [STAMP_W-1:0] elapsed;
        logic [STAMP_W-1:0] span;
        longint unsigned    quotient;
        logic [SLOT_W-1:0]  newest;
        res.wait_ms = '0;
        if (func == FUNC_QUERY)
        begin
            if (fill_count != 0)
            begin
                budget  = (int'(fill_count) * 50) / 3;
                elapsed = now_ms - stamps[oldest_index()];
                if (budget > elapsed)
                    res.wait_ms = ((budget - elapsed) > WAIT_MAX) ? WAIT_W'(WAIT_MAX)
                                                                  : WAIT_W'(budget - elapsed);
            end
        end
        else
        begin
            stamps[write_slot] = now_ms;
            write_slot = SLOT_W'((int'(write_slot) + 1) % WINDOW);
            if (fill_count < WINDOW)
                fill_count = fill_count + FILL_W'(1);
            frame_tally = frame_tally + TALLY_W'(1);
            if (frame_tally >= UPDATE_INTERVAL)
            begin
                if (fill_count == WINDOW)
                begin
                    newest = SLOT_W'((int'(write_slot) + WINDOW - 1) % WINDOW);
                    span   = stamps[newest] - stamps[oldest_index()];
                    if (span != 0)
                    begin
                        quotient = (64'd20000 * 64'(int'(fill_count) - 1) + 64'(span))
                                   / (64'd2 * 64'(span));
                        rate_value = (quotient > RATE_MAX) ? RATE_W'(RATE_MAX)
                                                           : RATE_W'(quotient);
                        rate_seen  = 1'b1;
                    end
                end
                frame_tally = '0;
            end
        end
        res.rate_tenths = rate_value;
        res.rate_valid  = rate_seen;
        return res;
    endfunction

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (cycle_count == 1500 || cycle_count == 6000)
            hold_left <= 600;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        frame_request_t req;
        pacing_result_t outcome;
        logic           calm;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= FUNC_QUERY;
        end
        else
        begin
            calm = (cycle_count >= 2500 && cycle_count < 5000);
            if (s_axis_tvalid && s_axis_tready)
            begin
                outcome = pacing_outcome(s_axis_tuser, s_axis_tdata);
                awaited_results.insert(awaited_results.size(), outcome);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (frame_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 24))
                begin
                    req = frame_requests[0];
                    frame_requests.delete(0);
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= req.now_ms;
                    s_axis_tuser  <= req.func;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (hold_left == 0) &&
                             ((cycle_count >= 2500 && cycle_count < 5000) ||
                              $urandom_range(0, 99) >= 24);
    end

    always @(posedge clk)
    begin : result_monitor
        pacing_result_t want;
        pacing_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.wait_ms     = m_axis_tdata[WAIT_W-1:0];
            got.rate_tenths = m_axis_tdata[OUT_DATA_W-1:WAIT_W];
            got.rate_valid  = m_axis_tuser;
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected result: wait %0d rate %0d valid %0d",
                             got.wait_ms, got.rate_tenths, got.rate_valid);
            end
            else
            begin
                want = awaited_results[0];
                awaited_results.delete(0);
                if (got.wait_ms != want.wait_ms || got.rate_tenths != want.rate_tenths ||
                    got.rate_valid != want.rate_valid)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Result mismatch: expected wait %0d rate %0d valid %0d, %s",
                                 want.wait_ms, want.rate_tenths, want.rate_valid,
                                 $sformatf("got wait %0d rate %0d valid %0d",
                                           got.wait_ms, got.rate_tenths, got.rate_valid));
                end
            end
        end
    end

    task automatic push_request(logic func, logic [STAMP_W-1:0] now_ms);
        frame_request_t req;
        req.func   = func;
        req.now_ms = now_ms;
        frame_requests.insert(frame_requests.size(), req);
    endtask

    task automatic push_queries(logic [STAMP_W-1:0] clock_ms, int unsigned step);
        int unsigned count;
        count = ($urandom_range(0, 9) < 4) ? $urandom_range(1, 2) : 0;
        repeat (count)
        begin
            if ($urandom_range(0, 19) == 0)
                push_request(FUNC_QUERY, $urandom);
            else
                push_request(FUNC_QUERY, clock_ms + $urandom_range(0, step + 4));
        end
    endtask

    initial
    begin
        logic [STAMP_W-1:0] clock_ms;
        int unsigned        run_len;
        int unsigned        step;
        int unsigned        kind;

        push_request(FUNC_QUERY,    32'h0000_0000);
        push_request(FUNC_QUERY,    32'hFFFF_FFFF);
        push_request(FUNC_REGISTER, 32'hFFFF_FFF0);
        push_request(FUNC_QUERY,    32'hFFFF_FFF0);
        push_request(FUNC_QUERY,    32'hFFFF_FFF8);
        push_request(FUNC_QUERY,    32'h0000_0005);
        push_request(FUNC_QUERY,    32'hFFFF_FFE0);
        push_request(FUNC_REGISTER, 32'h0000_0000);
        push_request(FUNC_QUERY,    32'h0000_0001);
        push_request(FUNC_REGISTER, 32'h0000_000F);
        push_request(FUNC_QUERY,    32'h7FFF_FFFF);
        push_request(FUNC_QUERY,    32'h8000_0000);
        push_request(FUNC_REGISTER, 32'hFFFF_FFFF);
        push_request(FUNC_QUERY,    32'hAAAA_AAAA);
        push_request(FUNC_QUERY,    32'h5555_5555);
        push_request(FUNC_REGISTER, 32'h5555_5555);

        clock_ms = 32'h5555_5555;
        while (frame_requests.size() < REQUEST_TOTAL)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                5:
                begin
                    run_len = $urandom_range(120, 130);
                    repeat (run_len)
                    begin
                        if ($urandom_range(0, 99) == 0)
                            clock_ms = clock_ms + 1;
                        push_queries(clock_ms, 0);
                        push_request(FUNC_REGISTER, clock_ms);
                    end
                end
                6: clock_ms = $urandom;
                7:
                begin
                    run_len = $urandom_range(10, 30);
                    repeat (run_len)
                        push_request($urandom_range(0, 1) ? FUNC_REGISTER : FUNC_QUERY, $urandom);
                end
                8:
                begin
                    run_len = $urandom_range(20, 80);
                    repeat (run_len)
                    begin
                        clock_ms = clock_ms + $urandom_range(0, 2);
                        push_queries(clock_ms, 2);
                        push_request(FUNC_REGISTER, clock_ms);
                    end
                end
                9: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                default:
                begin
                    run_len = $urandom_range(20, 140);
                    step = ($urandom_range(0, 7) == 0) ? $urandom_range(15000, 50000)
                                                       : $urandom_range(8, 40);
                    repeat (run_len)
                    begin
                        push_queries(clock_ms, step);
                        clock_ms = clock_ms + step - 3 + $urandom_range(0, 6);
                        push_request(FUNC_REGISTER, clock_ms);
                    end
                end
            endcase
        end
        while (frame_requests.size() > REQUEST_TOTAL)
            frame_requests.delete(frame_requests.size() - 1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (frame_requests.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
